@@ design/ste_pkg.sv @@
`default_nettype none
package ste_pkg;
  localparam int unsigned DataW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ChW = 8;
  localparam int unsigned SlotW = 4;
  localparam logic [TimeW-1:0] RefractoryReset = 32'd10000;
  localparam logic OpSample = 1'b0;
  localparam logic OpThresh = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [ChW-1:0]   channel;
    logic [DataW-1:0] sample;
    logic [TimeW-1:0] sample_time;
    logic [DataW-1:0] neg_threshold;
    logic [DataW-1:0] pos_threshold;
  } in_beat_t;

  typedef struct packed {
    logic [TimeW-1:0] spike_time;
    logic [ChW-1:0]   spike_channel;
    logic [SlotW-1:0] event_slot;
    logic [DataW-1:0] sample_value;
    logic             last_sample;
  } out_beat_t;

  typedef struct packed {
    logic clear;
    logic latch_in;
    logic state_rd;
    logic hist_rd;
    logic process;
    logic emit_start;
    logic emit_rd;
    logic emit_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic spike;
    logic emit_last;
  } ctrl_sts_t;
endpackage
`default_nettype wire

@@ design/ste_if.sv @@
`default_nettype none
interface ste_in_if;
  logic valid;
  logic ready;
  ste_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ste_out_if;
  logic valid;
  logic ready;
  ste_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/spike_threshold_extractor.sv @@
`default_nettype none
// Each item without a spike passes accept, state read, tap read and evaluate in turn;
// a new item is taken only once the last is through. A spike adds WINDOW_SAMPLES output
// beats, each a history read, then present, and stalls while out_if.ready is low.
// Reset (rst_ni, async low): refractory period returns to 10000, then a clearing
// pass over all NUM_CHANNELS channels zeroes thresholds, stamps, slots and fill counts.
module spike_threshold_extractor #(
  parameter int unsigned NUM_CHANNELS = 256,
  parameter int unsigned FIRST_DETECT_CHANNEL = 128,
  parameter int unsigned WINDOW_SAMPLES = 32,
  parameter int unsigned PRE_SAMPLES = 8,
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [ste_pkg::TimeW-1:0] cfg_wdata_i,
  ste_in_if.sink                         in_if,
  ste_out_if.source                      out_if
);
  import ste_pkg::*;

  logic [TimeW-1:0] refr_q;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refr_q <= RefractoryReset;
    end else if (cfg_we_i) begin
      refr_q <= cfg_wdata_i;
    end
  end

  ste_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  ste_datapath #(
    .NUM_CHANNELS(NUM_CHANNELS), .FIRST_DETECT_CHANNEL(FIRST_DETECT_CHANNEL),
    .WINDOW_SAMPLES(WINDOW_SAMPLES), .PRE_SAMPLES(PRE_SAMPLES), .SLOTS(SLOTS)
  ) u_dp (
    .clk_i, .rst_ni, .in_i(in_if.data), .refractory_i(refr_q),
    .cmd_i(cmd), .sts_o(sts), .out_o(out_if.data)
  );
endmodule
`default_nettype wire

@@ design/ste_ctrl.sv @@
`default_nettype none
module ste_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ste_pkg::ctrl_cmd_t     cmd_o,
  input  wire ste_pkg::ctrl_sts_t sts_i
);
  import ste_pkg::*;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StHist  = 3'd3;
  localparam logic [2:0] StEval  = 3'd4;
  localparam logic [2:0] StEmRd  = 3'd5;
  localparam logic [2:0] StEmOut = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.state_rd = 1'b1;
        state_d = StHist;
      end
      StHist: begin
        cmd_o.hist_rd = 1'b1;
        state_d = StEval;
      end
      StEval: begin
        cmd_o.process = 1'b1;
        if (sts_i.spike) begin
          cmd_o.emit_start = 1'b1;
          state_d = StEmRd;
        end else begin
          state_d = StIdle;
        end
      end
      StEmRd: begin
        cmd_o.emit_rd = 1'b1;
        state_d = StEmOut;
      end
      StEmOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_next = 1'b1;
          if (sts_i.emit_last) begin
            state_d = StIdle;
          end else begin
            state_d = StEmRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

@@ design/ste_datapath.sv @@
`default_nettype none
module ste_datapath #(
  parameter int unsigned NUM_CHANNELS = 256,
  parameter int unsigned FIRST_DETECT_CHANNEL = 128,
  parameter int unsigned WINDOW_SAMPLES = 32,
  parameter int unsigned PRE_SAMPLES = 8,
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ste_pkg::in_beat_t         in_i,
  input  wire logic [ste_pkg::TimeW-1:0] refractory_i,
  input  wire ste_pkg::ctrl_cmd_t        cmd_i,
  output ste_pkg::ctrl_sts_t             sts_o,
  output ste_pkg::out_beat_t             out_o
);
  import ste_pkg::*;

  localparam int unsigned ChIdxW = $clog2(NUM_CHANNELS);
  localparam int unsigned WinW = $clog2(WINDOW_SAMPLES);
  localparam int unsigned IdxSW = WinW + 1;
  localparam int unsigned FillW = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned SlotCW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned DPos = (PRE_SAMPLES < WINDOW_SAMPLES) ? PRE_SAMPLES
                                                                : WINDOW_SAMPLES - 1;
  localparam logic [TimeW-1:0] Back = TimeW'(WINDOW_SAMPLES - 1 - DPos);
  localparam int unsigned HistD = NUM_CHANNELS * WINDOW_SAMPLES;
  localparam int unsigned HistAW = $clog2(HistD);
  localparam logic [IdxSW-1:0] WinLen = IdxSW'(WINDOW_SAMPLES);
  localparam logic [IdxSW-1:0] TapOff = IdxSW'(DPos + 1);

  // Per-channel state, one entry per channel; history is a circular window
  // per channel, head pointing at the slot the next sample overwrites.
  logic [FillW-1:0]  fill_mem [NUM_CHANNELS];
  logic [WinW-1:0]   head_mem [NUM_CHANNELS];
  logic [DataW-1:0]  neg_mem [NUM_CHANNELS];
  logic [DataW-1:0]  pos_mem [NUM_CHANNELS];
  logic [TimeW-1:0]  stamp_mem [NUM_CHANNELS];
  logic [SlotCW-1:0] slot_mem [NUM_CHANNELS];
  logic [DataW-1:0]  hist_mem [HistD];

  in_beat_t          in_q;
  logic [ChIdxW-1:0] clr_q;
  logic [FillW-1:0]  fill_rd_q;
  logic [WinW-1:0]   head_rd_q;
  logic [DataW-1:0]  neg_rd_q;
  logic [DataW-1:0]  pos_rd_q;
  logic [TimeW-1:0]  stamp_rd_q;
  logic [SlotCW-1:0] slot_rd_q;
  logic [DataW-1:0]  hist_rd_q;
  logic [WinW-1:0]   start_q;
  logic [WinW-1:0]   emit_q;
  logic [TimeW-1:0]  spike_time_q;
  logic [SlotW-1:0]  slot_out_q;

  logic [ChIdxW-1:0] ch;
  logic [ChIdxW-1:0] st_addr;
  logic              ch_ok;
  logic              is_sample;
  logic              is_thresh;
  logic [FillW-1:0]  fill_new;
  logic              full;
  logic [IdxSW-1:0]  tap_sum;
  logic [IdxSW-1:0]  tap_wrap;
  logic [WinW-1:0]   tap_idx;
  logic [IdxSW-1:0]  head_sum;
  logic [WinW-1:0]   head_new;
  logic [IdxSW-1:0]  emit_sum;
  logic [IdxSW-1:0]  emit_wrap;
  logic [WinW-1:0]   emit_idx;
  logic [HistAW-1:0] ch_base;
  logic [HistAW-1:0] hist_raddr;
  logic [HistAW-1:0] hist_waddr;
  logic [DataW-1:0]  tested;
  logic              thr_hit;
  logic [TimeW-1:0]  stamp_new;
  logic              refr_ok;
  logic [31:0]       slot_ext;
  logic [31:0]       slot_inc;
  logic [SlotCW-1:0] slot_next;

  assign ch = in_q.channel[ChIdxW-1:0];
  assign ch_ok = 32'(in_q.channel) < NUM_CHANNELS;
  assign is_thresh = ch_ok && (in_q.opcode == OpThresh);
  assign is_sample = ch_ok && (in_q.opcode == OpSample)
                     && (32'(in_q.channel) >= FIRST_DETECT_CHANNEL);
  assign st_addr = cmd_i.clear ? clr_q : ch;

  assign fill_new = (fill_rd_q < FillW'(WINDOW_SAMPLES)) ? fill_rd_q + 1'b1 : fill_rd_q;
  assign full = fill_new == FillW'(WINDOW_SAMPLES);

  assign tap_sum = {1'b0, head_rd_q} + TapOff;
  assign tap_wrap = tap_sum - WinLen;
  assign tap_idx = (tap_sum >= WinLen) ? tap_wrap[WinW-1:0] : tap_sum[WinW-1:0];
  assign head_sum = {1'b0, head_rd_q} + IdxSW'(1);
  assign head_new = (head_sum == WinLen) ? '0 : head_sum[WinW-1:0];
  assign emit_sum = {1'b0, start_q} + {1'b0, emit_q};
  assign emit_wrap = emit_sum - WinLen;
  assign emit_idx = (emit_sum >= WinLen) ? emit_wrap[WinW-1:0] : emit_sum[WinW-1:0];

  assign ch_base = HistAW'(32'(ch) * WINDOW_SAMPLES);
  assign hist_raddr = ch_base + HistAW'(cmd_i.emit_rd ? emit_idx : tap_idx);
  assign hist_waddr = ch_base + HistAW'(head_rd_q);

  assign tested = (DPos == WINDOW_SAMPLES - 1) ? in_q.sample : hist_rd_q;
  assign thr_hit = ($signed(tested) < $signed(neg_rd_q))
                   || ($signed(tested) > $signed(pos_rd_q));
  assign stamp_new = in_q.sample_time - Back;
  assign refr_ok = (stamp_new - stamp_rd_q) > refractory_i;

  assign slot_ext = 32'(slot_rd_q);
  assign slot_inc = slot_ext + 32'd1;
  assign slot_next = (slot_inc >= SLOTS) ? '0 : SlotCW'(slot_inc);

  assign sts_o.clr_last = clr_q == ChIdxW'(NUM_CHANNELS - 1);
  assign sts_o.spike = is_sample && full && thr_hit && refr_ok;
  assign sts_o.emit_last = emit_q == WinW'(WINDOW_SAMPLES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_i;
    end
    if (cmd_i.emit_start) begin
      spike_time_q <= stamp_new;
      slot_out_q <= slot_ext[SlotW-1:0];
      start_q <= head_new;
      emit_q <= '0;
    end else if (cmd_i.emit_next) begin
      emit_q <= emit_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear || (cmd_i.process && is_thresh)) begin
      neg_mem[st_addr] <= cmd_i.clear ? '0 : in_q.neg_threshold;
      pos_mem[st_addr] <= cmd_i.clear ? '0 : in_q.pos_threshold;
    end
    if (cmd_i.clear || (cmd_i.process && is_sample)) begin
      fill_mem[st_addr] <= cmd_i.clear ? '0 : fill_new;
      head_mem[st_addr] <= cmd_i.clear ? '0 : head_new;
    end
    if (cmd_i.clear || cmd_i.emit_start) begin
      stamp_mem[st_addr] <= cmd_i.clear ? '0 : stamp_new;
      slot_mem[st_addr] <= cmd_i.clear ? '0 : slot_next;
    end
    if (cmd_i.state_rd) begin
      fill_rd_q <= fill_mem[ch];
      head_rd_q <= head_mem[ch];
      neg_rd_q <= neg_mem[ch];
      pos_rd_q <= pos_mem[ch];
      stamp_rd_q <= stamp_mem[ch];
      slot_rd_q <= slot_mem[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.process && is_sample) begin
      hist_mem[hist_waddr] <= in_q.sample;
    end
    if (cmd_i.hist_rd || cmd_i.emit_rd) begin
      hist_rd_q <= hist_mem[hist_raddr];
    end
  end

  assign out_o.spike_time = spike_time_q;
  assign out_o.spike_channel = in_q.channel;
  assign out_o.event_slot = slot_out_q;
  assign out_o.sample_value = hist_rd_q;
  assign out_o.last_sample = sts_o.emit_last;
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench;
  import ste_pkg::*;

  localparam int NCH = 256;
  localparam int FIRST_CH = 128;
  localparam int WIN = 32;
  localparam int TAP = 8;
  localparam int NSLOT = 16;

  class spike_window_model;
    logic [DataW-1:0] hist [NCH][WIN];
    int unsigned      fill [NCH];
    logic [TimeW-1:0] last_stamp [NCH];
    logic [DataW-1:0] neg_thr [NCH];
    logic [DataW-1:0] pos_thr [NCH];
    int unsigned      slot [NCH];
    logic [TimeW-1:0] refractory;
    out_beat_t        expected_beats [$];
    int               mismatches;

    function new();
      refractory = RefractoryReset;
      mismatches = 0;
      for (int c = 0; c < NCH; c++) begin
        fill[c] = 0;
        last_stamp[c] = '0;
        neg_thr[c] = '0;
        pos_thr[c] = '0;
        slot[c] = 0;
        for (int k = 0; k < WIN; k++) hist[c][k] = '0;
      end
    endfunction

    function void note_item(in_beat_t b);
      int c;
      logic signed [DataW-1:0] v;
      logic [TimeW-1:0] stamp;
      out_beat_t o;
      c = b.channel;
      if (b.opcode == OpThresh) begin
        neg_thr[c] = b.neg_threshold;
        pos_thr[c] = b.pos_threshold;
        return;
      end
      if (c < FIRST_CH) return;
      for (int k = 0; k < WIN - 1; k++) hist[c][k] = hist[c][k+1];
      hist[c][WIN-1] = b.sample;
      if (fill[c] < WIN) fill[c]++;
      if (fill[c] < WIN) return;
      v = hist[c][TAP];
      if (!(v < $signed(neg_thr[c]) || v > $signed(pos_thr[c]))) return;
      stamp = b.sample_time - TimeW'(WIN - 1 - TAP);
      if (TimeW'(stamp - last_stamp[c]) <= refractory) return;
      for (int k = 0; k < WIN; k++) begin
        o.spike_time = stamp;
        o.spike_channel = ChW'(c);
        o.event_slot = SlotW'(slot[c]);
        o.sample_value = hist[c][k];
        o.last_sample = (k == WIN - 1);
        expected_beats.push_back(o);
      end
      last_stamp[c] = stamp;
      slot[c] = (slot[c] + 1 >= NSLOT) ? 0 : slot[c] + 1;
    endfunction

    function void check_beat(out_beat_t a);
      out_beat_t e;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: t=%h ch=%0d slot=%0d val=%h last=%b",
                   a.spike_time, a.spike_channel, a.event_slot, a.sample_value,
                   a.last_sample);
        return;
      end
      e = expected_beats.pop_front();
      if (a.spike_time !== e.spike_time || a.spike_channel !== e.spike_channel ||
          a.event_slot !== e.event_slot || a.sample_value !== e.sample_value ||
          a.last_sample !== e.last_sample) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("beat mismatch: exp t=%h ch=%0d slot=%0d val=%h last=%b",
                   e.spike_time, e.spike_channel, e.event_slot, e.sample_value,
                   e.last_sample);
          $display("               got t=%h ch=%0d slot=%0d val=%h last=%b",
                   a.spike_time, a.spike_channel, a.event_slot, a.sample_value,
                   a.last_sample);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [TimeW-1:0] cfg_wdata_i;
  ste_in_if in_bus ();
  ste_out_if out_bus ();

  spike_threshold_extractor u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  spike_window_model model = new();
  logic [TimeW-1:0] chan_time [NCH];
  bit steady_rx;
  int rx_hold;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_bus.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_bus.ready <= 1'b1;
      if (!steady_rx && $urandom_range(0, 5) == 0)
        rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_bus.valid && out_bus.ready) model.check_beat(out_bus.data);

  task automatic send_beat(in_beat_t b);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data <= b;
    do @(posedge clk_i); while (!in_bus.ready);
    model.note_item(b);
    @(negedge clk_i);
  endtask

  task automatic send_thresh(int c, logic [DataW-1:0] lo, logic [DataW-1:0] hi);
    in_beat_t b;
    b = '0;
    b.opcode = OpThresh;
    b.channel = ChW'(c);
    b.sample = DataW'($urandom);
    b.sample_time = $urandom;
    b.neg_threshold = lo;
    b.pos_threshold = hi;
    send_beat(b);
  endtask

  task automatic send_sample(int c, logic [DataW-1:0] v);
    in_beat_t b;
    b = '0;
    b.opcode = OpSample;
    b.channel = ChW'(c);
    b.sample = v;
    b.sample_time = chan_time[c];
    b.neg_threshold = DataW'($urandom);
    b.pos_threshold = DataW'($urandom);
    chan_time[c] = chan_time[c] + TimeW'($urandom_range(1, 3));
    send_beat(b);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (model.expected_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_refractory(logic [TimeW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model.refractory = v;
    @(negedge clk_i);
  endtask

  function automatic logic [DataW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return DataW'($urandom);
      default: return DataW'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  task automatic random_phase(int n);
    int chs [4] = '{128, 129, 200, 255};
    int c;
    for (int i = 0; i < n; i++) begin
      c = chs[$urandom_range(0, 3)];
      case ($urandom_range(0, 19))
        0: send_sample($urandom_range(0, FIRST_CH - 1), DataW'($urandom));
        1: send_thresh(c, DataW'(-$urandom_range(50, 2000)), DataW'($urandom_range(50, 2000)));
        2: send_thresh($urandom_range(0, 255), DataW'($urandom), DataW'($urandom));
        default: send_sample(c, rand_value());
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    out_bus.ready = 1'b0;
    steady_rx = 1'b0;
    rx_hold = 0;
    for (int c = 0; c < NCH; c++) chan_time[c] = $urandom_range(20000, 1 << 30);
    chan_time[128] = 32'd20000;
    chan_time[129] = 32'hffff_ffe0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, ignored channels, one clean spike on 128
    send_thresh(0, 16'h8000, 16'h7fff);
    send_thresh(255, 16'h8000, 16'h7fff);
    send_thresh(128, DataW'(-50), DataW'(50));
    send_sample(0, 16'h8000);
    send_sample(127, 16'h7fff);
    for (int k = 0; k < WIN + 3; k++)
      send_sample(128, (k == TAP) ? 16'h7fff : (k == TAP + 1) ? 16'h8000 : 16'h0000);
    drain();

    // sample time on 129 wraps through zero while its window fills
    write_refractory('0);
    send_thresh(129, DataW'(-300), DataW'(300));
    for (int k = 0; k < WIN; k++) send_sample(129, rand_value());
    random_phase(15);
    drain();

    write_refractory('1);
    steady_rx = 1'b1;
    random_phase(8);
    drain();

    steady_rx = 1'b0;
    write_refractory(TimeW'($urandom_range(1, 40)));
    random_phase(10);
    drain();

    write_refractory(RefractoryReset);
    random_phase(4);
    drain();
    repeat (20) @(posedge clk_i);

    if (model.mismatches == 0 && model.expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
